>>> hdl/usps_pkg.sv
// Shared types, constants and helpers of the UV sphere point generator.
// No dependencies; every other file in hdl/ imports this package.
package usps_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_RADIUS      = 3'd0;
	localparam logic [2:0] REG_CENTER_X    = 3'd1;
	localparam logic [2:0] REG_CENTER_Y    = 3'd2;
	localparam logic [2:0] REG_CENTER_Z    = 3'd3;
	localparam logic [2:0] REG_SECTORS     = 3'd4;
	localparam logic [2:0] REG_STACKS      = 3'd5;
	localparam logic [2:0] REG_FIRST_INDEX = 3'd6;

	// Result item codes
	localparam logic [1:0] CODE_VTX_MORE = 2'd0;
	localparam logic [1:0] CODE_VTX_LAST = 2'd1;
	localparam logic [1:0] CODE_TRI_MORE = 2'd2;
	localparam logic [1:0] CODE_TRI_LAST = 2'd3;

	localparam logic [8:0] MAX_SECTORS = 9'd256;
	localparam logic [8:0] MAX_STACKS  = 9'd256;

	// Reciprocal scaling: recip = floor(2^RCP_SHIFT / count)
	localparam int RCP_SHIFT = 25;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam int NUM_W     = 25;
	localparam logic [RCP_W-1:0] RCP_SECT_RST = RCP_W'((1 << RCP_SHIFT) / 16);
	localparam logic [RCP_W-1:0] RCP_STCK_RST = RCP_W'((1 << RCP_SHIFT) / 8);

	localparam logic [16:0] TEX_ONE = 17'd65536;
	localparam logic [15:0] QUARTER_TURN = 16'h4000;

	// CORDIC
	localparam int CORDIC_STEPS = 20;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [8:0] row;
		logic [8:0] column;
	} usps_in_t;

	typedef struct packed {
		logic [1:0]         item_code;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [16:0]        tex_s;
		logic [16:0]        tex_t;
		logic [31:0]        corner_a;
		logic [31:0]        corner_b;
		logic [31:0]        corner_c;
	} usps_out_t;

	// Classified point handed from front to back
	typedef struct packed {
		logic [15:0] sec_ph;
		logic [15:0] stk_ph;
		logic [16:0] tex_s;
		logic [16:0] tex_t;
		logic        tri_up;
		logic        tri_dn;
		logic [31:0] base1;
		logic [31:0] base2;
	} usps_work_t;

	// Zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [8:0] eff_count(input logic [8:0] v, input logic [8:0] mx);
		if (v == 9'd0)
			return 9'd1;
		if (v > mx)
			return mx;
		return v;
	endfunction

endpackage

>>> hdl/usps_recip.sv
// Sequential reciprocal unit: floor(2^25 / count) for sector and stack counts.
// Depends on usps_pkg. Each count write starts a new division.
module usps_recip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [8:0]                   sectors,
	input  logic [8:0]                   stacks,
	output logic [usps_pkg::RCP_W-1:0]   recip_s,
	output logic [usps_pkg::RCP_W-1:0]   recip_t,
	output logic                         busy
);
	import usps_pkg::*;

	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [8:0]       rem_s_q, rem_t_q;
	logic [RCP_W-1:0] quo_s_q, quo_t_q;
	logic [RCP_W-1:0] rcp_s_q, rcp_t_q;
	logic             bit_in;
	logic [9:0]       sh_s, sh_t;
	logic             ge_s, ge_t;
	logic [9:0]       nx_s, nx_t;

	// Dividend is 2^25: a single one at the top, zeros after
	assign bit_in = (cnt_q == 5'(RCP_W));
	assign sh_s = {rem_s_q, bit_in};
	assign sh_t = {rem_t_q, bit_in};
	assign ge_s = sh_s >= {1'b0, sectors};
	assign ge_t = sh_t >= {1'b0, stacks};
	assign nx_s = ge_s ? sh_s - {1'b0, sectors} : sh_s;
	assign nx_t = ge_t ? sh_t - {1'b0, stacks} : sh_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			rcp_s_q <= RCP_SECT_RST;
			rcp_t_q <= RCP_STCK_RST;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(RCP_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q  <= 1'b0;
				rcp_s_q <= {quo_s_q[RCP_W-2:0], ge_s};
				rcp_t_q <= {quo_t_q[RCP_W-2:0], ge_t};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_s_q <= '0;
			rem_t_q <= '0;
			quo_s_q <= '0;
			quo_t_q <= '0;
		end else if (busy_q) begin
			rem_s_q <= nx_s[8:0];
			rem_t_q <= nx_t[8:0];
			quo_s_q <= {quo_s_q[RCP_W-2:0], ge_s};
			quo_t_q <= {quo_t_q[RCP_W-2:0], ge_t};
		end
	end

	assign recip_s = rcp_s_q;
	assign recip_t = rcp_t_q;
	assign busy    = busy_q;

endmodule

>>> hdl/usps_front.sv
// Front end: accepts grid points, derives phases, texture coordinates and
// triangle plan through a four-stage pipeline. Depends on usps_pkg.
module usps_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  usps_pkg::usps_in_t          pt,
	input  logic [8:0]                  sectors,
	input  logic [8:0]                  stacks,
	input  logic [usps_pkg::RCP_W-1:0]  recip_s,
	input  logic [usps_pkg::RCP_W-1:0]  recip_t,
	input  logic [31:0]                 first_index,
	input  logic                        q_full,
	output logic                        ready,
	output logic                        push,
	output usps_pkg::usps_work_t        wk
);
	import usps_pkg::*;

	logic en;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	logic [8:0]       i_s1, j_s1;
	logic [NUM_W-1:0] ns_s1, na_s1, nt_s1, ns_s2, na_s2, nt_s2, ns_s3, na_s3, nt_s3;
	logic [NUM_W-1:0] qs_s2, qa_s2, qt_s2, qs_s3, qa_s3, qt_s3;
	logic [33:0]      ds_s3, da_s3, dt_s3;
	logic [31:0]      k1_s2, b1_s3, b2_s3;
	logic             up_s2, dn_s2, up_s3, dn_s3;
	usps_work_t       wk_s4;

	logic [50:0] ps, pa, pt_prod;
	logic [18:0] row_base;
	logic [NUM_W-1:0] qs_f, qa_f, qt_f;

	// Reciprocal estimate may be one low; the next stages correct it
	assign ps      = ns_s1 * recip_s;
	assign pa      = na_s1 * recip_t;
	assign pt_prod = nt_s1 * recip_t;
	assign row_base = i_s1 * ({1'b0, sectors} + 10'd1);

	function automatic logic [NUM_W-1:0] fix_q(input logic [NUM_W-1:0] n,
			input logic [NUM_W-1:0] qe, input logic [33:0] qd, input logic [8:0] d);
		logic [NUM_W-1:0] r;
		r = n - qd[NUM_W-1:0];
		return (r[9:0] >= {1'b0, d}) ? qe + NUM_W'(1) : qe;
	endfunction

	function automatic logic [16:0] sat_tex(input logic [NUM_W-1:0] q);
		return (q > NUM_W'(TEX_ONE)) ? TEX_ONE : q[16:0];
	endfunction

	assign qs_f = fix_q(ns_s3, qs_s3, ds_s3, sectors);
	assign qa_f = fix_q(na_s3, qa_s3, da_s3, stacks);
	assign qt_f = fix_q(nt_s3, qt_s3, dt_s3, stacks);

	assign en    = !v4_s4 || !q_full;
	assign ready = en;
	assign push  = v4_s4 && !q_full;
	assign wk    = wk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else if (en) begin
			v1_s1 <= take;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: rounded numerators
			i_s1  <= pt.row;
			j_s1  <= pt.column;
			ns_s1 <= {pt.column, 16'b0} + NUM_W'(sectors >> 1);
			na_s1 <= {1'b0, pt.row, 15'b0} + NUM_W'(stacks >> 1);
			nt_s1 <= {pt.row, 16'b0} + NUM_W'(stacks >> 1);
			// s2: quotient estimates and grid position
			ns_s2 <= ns_s1;
			na_s2 <= na_s1;
			nt_s2 <= nt_s1;
			qs_s2 <= ps[49:25];
			qa_s2 <= pa[49:25];
			qt_s2 <= pt_prod[49:25];
			k1_s2 <= {13'b0, row_base} + {23'b0, j_s1};
			up_s2 <= (i_s1 < stacks) && (j_s1 < sectors) && (i_s1 != 9'd0);
			dn_s2 <= (i_s1 < stacks) && (j_s1 < sectors) && (i_s1 != stacks - 9'd1);
			// s3: back-multiply for the remainder check
			ns_s3 <= ns_s2;
			na_s3 <= na_s2;
			nt_s3 <= nt_s2;
			qs_s3 <= qs_s2;
			qa_s3 <= qa_s2;
			qt_s3 <= qt_s2;
			ds_s3 <= qs_s2 * sectors;
			da_s3 <= qa_s2 * stacks;
			dt_s3 <= qt_s2 * stacks;
			b1_s3 <= k1_s2 + first_index;
			b2_s3 <= k1_s2 + {23'b0, sectors} + 32'd1 + first_index;
			up_s3 <= up_s2;
			dn_s3 <= dn_s2;
			// s4: corrected quotients
			wk_s4.sec_ph <= qs_f[15:0];
			wk_s4.stk_ph <= QUARTER_TURN - qa_f[15:0];
			wk_s4.tex_s  <= sat_tex(qs_f);
			wk_s4.tex_t  <= sat_tex(qt_f);
			wk_s4.tri_up <= up_s3;
			wk_s4.tri_dn <= dn_s3;
			wk_s4.base1  <= b1_s3;
			wk_s4.base2  <= b2_s3;
		end
	end

endmodule

>>> hdl/usps_fifo.sv
// Short queue between front and back end.
// Depends on usps_pkg for the entry type and depth.
module usps_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  usps_pkg::usps_work_t wr_data,
	input  logic                 pop,
	output usps_pkg::usps_work_t rd_data,
	output logic                 full,
	output logic                 empty
);
	import usps_pkg::*;

	usps_work_t        mem_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_data;
	end

endmodule

>>> hdl/usps_back.sv
// Back end: dual CORDIC pipeline, normal and position math, and the output
// sequencer that emits the vertex and its triangles. Depends on usps_pkg.
module usps_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  usps_pkg::usps_work_t q_data,
	output logic                 pop,
	input  logic [30:0]          radius,
	input  logic [31:0]          center_x,
	input  logic [31:0]          center_y,
	input  logic [31:0]          center_z,
	output logic                 res_valid,
	output usps_pkg::usps_out_t  res,
	input  logic                 res_stall
);
	import usps_pkg::*;

	localparam int NS = CORDIC_STEPS;

	logic en, free, take;

	// CORDIC stages 0..NS: a = sector angle, b = stack angle
	logic              v_s  [0:NS];
	logic signed [33:0] xa_s [0:NS], ya_s [0:NS], xb_s [0:NS], yb_s [0:NS];
	logic signed [31:0] za_s [0:NS], zb_s [0:NS];
	logic [1:0]         qa_s [0:NS], qb_s [0:NS];
	usps_work_t         wk_s [0:NS];

	logic               v_s21, v_s22, v_s23, v_s24;
	logic signed [15:0] cs_s21, ss_s21, ct_s21, st_s21;
	logic signed [15:0] nx_s22, ny_s22, nz_s22, nx_s23, ny_s23, nz_s23, nx_s24, ny_s24, nz_s24;
	logic signed [47:0] px_s23, py_s23, pz_s23;
	logic [31:0]        pos_x_s24, pos_y_s24, pos_z_s24;
	usps_work_t         wk_s21, wk_s22, wk_s23, wk_s24;

	logic signed [31:0] pxx, pxy;
	logic signed [31:0] rad_s;

	usps_out_t  res_q, tri0_q, tri1_q;
	logic       res_valid_q;
	logic [1:0] pend_q;

	function automatic logic signed [15:0] rnd_clamp(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd32768) >>> 16;
		if (t > 34'sd16384)
			return 16'sd16384;
		if (t < -34'sd16384)
			return -16'sd16384;
		return t[15:0];
	endfunction

	function automatic logic [31:0] rnd_pos(input logic [31:0] c, input logic signed [47:0] p);
		logic signed [47:0] t;
		t = (p + 48'sd8192) >>> 14;
		return c + t[31:0];
	endfunction

	function automatic usps_out_t mk_tri(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic last);
		usps_out_t o;
		o = '0;
		o.item_code = last ? CODE_TRI_LAST : CODE_TRI_MORE;
		o.corner_a  = a;
		o.corner_b  = b;
		o.corner_c  = c;
		return o;
	endfunction

	assign free = !res_valid_q || !res_stall;
	assign take = free && (pend_q == 2'd0) && v_s24;
	assign en   = !v_s24 || take;
	assign pop  = en && !q_empty;

	assign pxx   = ct_s21 * cs_s21;
	assign pxy   = ct_s21 * ss_s21;
	assign rad_s = $signed({1'b0, radius});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++)
				v_s[k] <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
			v_s24 <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_empty;
			for (int k = 0; k < NS; k++)
				v_s[k+1] <= v_s[k];
			v_s21 <= v_s[NS];
			v_s22 <= v_s21;
			v_s23 <= v_s22;
			v_s24 <= v_s23;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 0: quadrant split, rotator init
			xa_s[0] <= CORDIC_X0;
			ya_s[0] <= '0;
			za_s[0] <= {2'b00, q_data.sec_ph[13:0], 16'b0};
			qa_s[0] <= q_data.sec_ph[15:14];
			xb_s[0] <= CORDIC_X0;
			yb_s[0] <= '0;
			zb_s[0] <= {2'b00, q_data.stk_ph[13:0], 16'b0};
			qb_s[0] <= q_data.stk_ph[15:14];
			wk_s[0] <= q_data;
			// one micro-rotation per stage, floor shifts
			for (int k = 0; k < NS; k++) begin
				if (!za_s[k][31]) begin
					xa_s[k+1] <= xa_s[k] - (ya_s[k] >>> k);
					ya_s[k+1] <= ya_s[k] + (xa_s[k] >>> k);
					za_s[k+1] <= za_s[k] - $signed(ATAN_TURN[k]);
				end else begin
					xa_s[k+1] <= xa_s[k] + (ya_s[k] >>> k);
					ya_s[k+1] <= ya_s[k] - (xa_s[k] >>> k);
					za_s[k+1] <= za_s[k] + $signed(ATAN_TURN[k]);
				end
				if (!zb_s[k][31]) begin
					xb_s[k+1] <= xb_s[k] - (yb_s[k] >>> k);
					yb_s[k+1] <= yb_s[k] + (xb_s[k] >>> k);
					zb_s[k+1] <= zb_s[k] - $signed(ATAN_TURN[k]);
				end else begin
					xb_s[k+1] <= xb_s[k] + (yb_s[k] >>> k);
					yb_s[k+1] <= yb_s[k] - (xb_s[k] >>> k);
					zb_s[k+1] <= zb_s[k] + $signed(ATAN_TURN[k]);
				end
				qa_s[k+1] <= qa_s[k];
				qb_s[k+1] <= qb_s[k];
				wk_s[k+1] <= wk_s[k];
			end
			// s21: round to Q1.14 and fold the quadrant back in
			case (qa_s[NS])
				2'd0: begin
					cs_s21 <= rnd_clamp(xa_s[NS]);
					ss_s21 <= rnd_clamp(ya_s[NS]);
				end
				2'd1: begin
					cs_s21 <= -rnd_clamp(ya_s[NS]);
					ss_s21 <= rnd_clamp(xa_s[NS]);
				end
				2'd2: begin
					cs_s21 <= -rnd_clamp(xa_s[NS]);
					ss_s21 <= -rnd_clamp(ya_s[NS]);
				end
				default: begin
					cs_s21 <= rnd_clamp(ya_s[NS]);
					ss_s21 <= -rnd_clamp(xa_s[NS]);
				end
			endcase
			case (qb_s[NS])
				2'd0: begin
					ct_s21 <= rnd_clamp(xb_s[NS]);
					st_s21 <= rnd_clamp(yb_s[NS]);
				end
				2'd1: begin
					ct_s21 <= -rnd_clamp(yb_s[NS]);
					st_s21 <= rnd_clamp(xb_s[NS]);
				end
				2'd2: begin
					ct_s21 <= -rnd_clamp(xb_s[NS]);
					st_s21 <= -rnd_clamp(yb_s[NS]);
				end
				default: begin
					ct_s21 <= rnd_clamp(yb_s[NS]);
					st_s21 <= -rnd_clamp(xb_s[NS]);
				end
			endcase
			wk_s21 <= wk_s[NS];
			// s22: normal
			nx_s22 <= 16'((pxx + 32'sd8192) >>> 14);
			ny_s22 <= 16'((pxy + 32'sd8192) >>> 14);
			nz_s22 <= st_s21;
			wk_s22 <= wk_s21;
			// s23: radius times normal
			px_s23 <= rad_s * nx_s22;
			py_s23 <= rad_s * ny_s22;
			pz_s23 <= rad_s * nz_s22;
			nx_s23 <= nx_s22;
			ny_s23 <= ny_s22;
			nz_s23 <= nz_s22;
			wk_s23 <= wk_s22;
			// s24: add center, wrap to 32 bits
			pos_x_s24 <= rnd_pos(center_x, px_s23);
			pos_y_s24 <= rnd_pos(center_y, py_s23);
			pos_z_s24 <= rnd_pos(center_z, pz_s23);
			nx_s24 <= nx_s23;
			ny_s24 <= ny_s23;
			nz_s24 <= nz_s23;
			wk_s24 <= wk_s23;
		end
	end

	// Output sequencer: vertex first, then pending triangles one per cycle while res_stall is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_q      <= 2'd0;
		end else if (free) begin
			if (pend_q != 2'd0) begin
				res_valid_q <= 1'b1;
				pend_q      <= pend_q - 2'd1;
			end else if (v_s24) begin
				res_valid_q <= 1'b1;
				pend_q      <= {1'b0, wk_s24.tri_up} + {1'b0, wk_s24.tri_dn};
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (pend_q != 2'd0) begin
				res_q  <= tri0_q;
				tri0_q <= tri1_q;
			end else if (v_s24) begin
				res_q           <= '0;
				res_q.item_code <= (wk_s24.tri_up || wk_s24.tri_dn) ?
					CODE_VTX_MORE : CODE_VTX_LAST;
				res_q.pos_x  <= pos_x_s24;
				res_q.pos_y  <= pos_y_s24;
				res_q.pos_z  <= pos_z_s24;
				res_q.norm_x <= nx_s24;
				res_q.norm_y <= ny_s24;
				res_q.norm_z <= nz_s24;
				res_q.tex_s  <= wk_s24.tex_s;
				res_q.tex_t  <= wk_s24.tex_t;
				if (wk_s24.tri_up) begin
					tri0_q <= mk_tri(wk_s24.base1, wk_s24.base2,
						wk_s24.base1 + 32'd1, !wk_s24.tri_dn);
					tri1_q <= mk_tri(wk_s24.base1 + 32'd1, wk_s24.base2,
						wk_s24.base2 + 32'd1, 1'b1);
				end else begin
					tri0_q <= mk_tri(wk_s24.base1 + 32'd1, wk_s24.base2,
						wk_s24.base2 + 32'd1, 1'b1);
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hdl/uv_sphere_point_generator.sv
// Top level of the UV sphere point generator: config registers, reciprocal
// unit, front end, queue and back end. Depends on usps_pkg and all usps_* modules.
//
// Usage:
//   pt channel   : one grid point (row, column) per item; taken when pt_valid
//                  is high and pt_stall is low.
//   res channel  : result items (vertex, then up to two triangles); taken when
//                  res_valid is high and res_stall is low. Registered output.
//   cfg channel  : register writes (index, data) on cfg_valid && cfg_ready.
// Path: a point goes through the front stages, the queue, 21 CORDIC stages,
//   4 rounding and math stages and the output register before its vertex is on res.
//   The result port carries one item per cycle while res_stall is low, and a point's
//   triangles follow its vertex; front and back run across a 4-entry queue.
// Writing sector_count or stack_count starts a reciprocal
//   computation; pt_stall and cfg_ready hold the block off while it runs.
// Reset: registers take their reset values, reciprocals are preset for the
//   reset counts, all pipelines are empty; no clearing pass is needed.
// Receiver stall: the back pipeline freezes, the queue fills, then the front
//   freezes and pt_stall rises. Nothing is dropped.
module uv_sphere_point_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_stall,
	input  usps_pkg::usps_in_t  pt,
	output logic                res_valid,
	input  logic                res_stall,
	output usps_pkg::usps_out_t res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import usps_pkg::*;

	logic [30:0] radius_q;
	logic [31:0] center_x_q, center_y_q, center_z_q, first_index_q;
	logic [8:0]  sector_count_q, stack_count_q;
	logic [8:0]  sectors, stacks;

	logic             cfg_wr, rcp_start, rcp_busy;
	logic [RCP_W-1:0] recip_s, recip_t;
	logic             front_ready, take, push, q_full, q_empty, pop;
	usps_work_t       wk_in, wk_out;

	assign cfg_ready = !rcp_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign rcp_start = cfg_wr && (cfg_index == REG_SECTORS || cfg_index == REG_STACKS);

	// Config registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= 31'd65536;
			center_x_q     <= '0;
			center_y_q     <= '0;
			center_z_q     <= '0;
			sector_count_q <= 9'd16;
			stack_count_q  <= 9'd8;
			first_index_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_RADIUS:      radius_q       <= cfg_data[30:0];
				REG_CENTER_X:    center_x_q     <= cfg_data;
				REG_CENTER_Y:    center_y_q     <= cfg_data;
				REG_CENTER_Z:    center_z_q     <= cfg_data;
				REG_SECTORS:     sector_count_q <= cfg_data[8:0];
				REG_STACKS:      stack_count_q  <= cfg_data[8:0];
				REG_FIRST_INDEX: first_index_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective counts: zero acts as one, clipped at the maximum
	assign sectors = eff_count(sector_count_q, MAX_SECTORS);
	assign stacks  = eff_count(stack_count_q, MAX_STACKS);

	usps_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rcp_start),
		.sectors (sectors),
		.stacks  (stacks),
		.recip_s (recip_s),
		.recip_t (recip_t),
		.busy    (rcp_busy)
	);

	assign pt_stall = !front_ready || rcp_busy;
	assign take     = pt_valid && !pt_stall;

	usps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.pt          (pt),
		.sectors     (sectors),
		.stacks      (stacks),
		.recip_s     (recip_s),
		.recip_t     (recip_t),
		.first_index (first_index_q),
		.q_full      (q_full),
		.ready       (front_ready),
		.push        (push),
		.wk          (wk_in)
	);

	usps_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wk_in),
		.pop     (pop),
		.rd_data (wk_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	usps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (wk_out),
		.pop       (pop),
		.radius    (radius_q),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.center_z  (center_z_q),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

	// A vertex announcing more is followed at once by a triangle
	a_vtx_then_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res.item_code == CODE_VTX_MORE) |=>
		(res_valid && (res.item_code == CODE_TRI_MORE || res.item_code == CODE_TRI_LAST)))
		else $error("vertex with more items not followed by a triangle");

	// A non-final triangle is followed at once by the final one
	a_tri_then_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && res.item_code == CODE_TRI_MORE) |=>
		(res_valid && res.item_code == CODE_TRI_LAST))
		else $error("triangle with more items not followed by the last triangle");

	// Queue never takes an entry while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full))
		else $error("push into full queue");

endmodule

>>> bench/uv_sphere_point_generator_tb.sv
// Testbench for the UV sphere point generator: grid points in, vertices and index triangles out.
// A local predictor computes each point's vertex and triangles; depends on usps_pkg and the RTL.
`timescale 1ns / 1ps

module uv_sphere_point_generator_tb;
	import usps_pkg::*;

	logic clk, arst_n;
	logic pt_valid, pt_stall;
	usps_in_t pt;
	logic res_valid, res_stall;
	usps_out_t res;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	uv_sphere_point_generator dut (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the sphere settings
	logic [30:0] sh_radius;
	logic [31:0] sh_cx, sh_cy, sh_cz;
	logic [8:0]  sh_sectors, sh_stacks;
	logic [31:0] sh_first;

	usps_in_t  point_q[$];
	usps_out_t mesh_q[$];
	int mismatches, results_seen, points_sent, cycle_cnt;

	localparam logic [31:0] ARCTAN_TBL [0:19] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Q1.14 clamp after rounding from Q2.30
	function automatic longint to_q14(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	// Quadrant fold plus 20-step rotation; angle is a 16-bit fraction of a turn
	task automatic sincos(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] a;
		longint x, y, z, xs, ys, cc, ss;
		a = {ang, 16'd0};
		x = 652032874; y = 0; z = a[29:0];
		for (int k = 0; k < 20; k++) begin
			xs = x >>> k; ys = y >>> k;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ARCTAN_TBL[k];
			end else begin
				x += ys; y -= xs; z += ARCTAN_TBL[k];
			end
		end
		cc = to_q14(x); ss = to_q14(y);
		case (a[31:30])
			2'd0: begin c = cc; s = ss; end
			2'd1: begin c = -ss; s = cc; end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endtask

	function automatic longint rnd14(input longint p);
		return (p + 8192) >>> 14;
	endfunction

	function automatic longint tex_frac(input longint n, input longint d);
		longint t;
		t = (n * 65536 + d / 2) / d;
		return t > 65536 ? 65536 : t;
	endfunction

	function automatic usps_out_t make_tri(input logic [31:0] a, b, c);
		usps_out_t t;
		t = '0;
		t.item_code = CODE_TRI_MORE;
		t.corner_a = a + sh_first;
		t.corner_b = b + sh_first;
		t.corner_c = c + sh_first;
		return t;
	endfunction

	// Vertex, then upper and lower triangle where the grid allows them
	task automatic predict_mesh(input usps_in_t p);
		longint s_cnt, t_cnt, i, j, cs, ss, ct, st, nx, ny, nz, r;
		logic [15:0] sec_ph, stk_ph;
		logic [31:0] k1, k2;
		usps_out_t v;
		usps_out_t items[$];
		s_cnt = eff_count(sh_sectors, MAX_SECTORS);
		t_cnt = eff_count(sh_stacks, MAX_STACKS);
		i = p.row; j = p.column;
		sec_ph = 16'(((j << 16) + s_cnt / 2) / s_cnt);
		stk_ph = 16'h4000 - 16'(((i << 15) + t_cnt / 2) / t_cnt);
		sincos(sec_ph, cs, ss);
		sincos(stk_ph, ct, st);
		nx = rnd14(ct * cs); ny = rnd14(ct * ss); nz = st;
		r = sh_radius;
		v = '0;
		v.item_code = CODE_VTX_MORE;
		v.pos_x = 32'($signed(sh_cx) + rnd14(r * nx));
		v.pos_y = 32'($signed(sh_cy) + rnd14(r * ny));
		v.pos_z = 32'($signed(sh_cz) + rnd14(r * nz));
		v.norm_x = 16'(nx); v.norm_y = 16'(ny); v.norm_z = 16'(nz);
		v.tex_s = 17'(tex_frac(j, s_cnt));
		v.tex_t = 17'(tex_frac(i, t_cnt));
		items = {items, v};
		if (i < t_cnt && j < s_cnt) begin
			k1 = 32'(i * (s_cnt + 1) + j);
			k2 = k1 + 32'(s_cnt + 1);
			if (i != 0) items = {items, make_tri(k1, k2, k1 + 1)};
			if (i != t_cnt - 1) items = {items, make_tri(k1 + 1, k2, k2 + 1)};
		end
		items[items.size() - 1].item_code[0] = 1'b1;
		foreach (items[n]) mesh_q = {mesh_q, items[n]};
	endtask

	function automatic int gap_len();
		int g;
		g = $urandom_range(0, 99);
		if (g < 55) return 0;
		if (g < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Driver: presents queued points with random gaps between them
	int send_gap;
	int next_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
			pt <= '0;
			send_gap <= 0;
		end else if (pt_valid && !pt_stall) begin
			predict_mesh(pt);
			points_sent <= points_sent + 1;
			void'(point_q.pop_front());
			next_gap = gap_len();
			if (next_gap == 0 && point_q.size() > 0) begin
				pt <= point_q[0];
			end else begin
				pt_valid <= 1'b0;
			end
			send_gap <= next_gap;
		end else if (!pt_valid) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (point_q.size() > 0) begin
				pt_valid <= 1'b1;
				pt <= point_q[0];
			end
		end
	end

	// Monitor: random back-pressure, compares each item with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (mesh_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item %p", res);
				end else begin
					if (res !== mesh_q[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p\n          actual   %p",
								mesh_q[0], res);
					end
					void'(mesh_q.pop_front());
				end
			end
			res_stall <= (gap_len() != 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 400000) begin
			$display("timeout, %0d items still expected", mesh_q.size());
			$display("[uv_sphere_point_generator] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RADIUS:      sh_radius = val[30:0];
			REG_CENTER_X:    sh_cx = val;
			REG_CENTER_Y:    sh_cy = val;
			REG_CENTER_Z:    sh_cz = val;
			REG_SECTORS:     sh_sectors = val[8:0];
			REG_STACKS:      sh_stacks = val[8:0];
			REG_FIRST_INDEX: sh_first = val;
			default: ;
		endcase
	endtask

	// Lets every queued point pass and its results drain
	task automatic drain();
		while (point_q.size() != 0 || pt_valid || mesh_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic add_point(input int r, input int c);
		usps_in_t p;
		p.row = 9'(r); p.column = 9'(c);
		point_q = {point_q, p};
	endtask

	initial begin
		int s, t, kind;
		arst_n = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		mismatches = 0; results_seen = 0; points_sent = 0; cycle_cnt = 0;
		sh_radius = 31'd65536; sh_cx = 0; sh_cy = 0; sh_cz = 0;
		sh_sectors = 9'd16; sh_stacks = 9'd8; sh_first = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, poles, last row, outside the grid, field extremes
		add_point(0, 0); add_point(1, 3); add_point(7, 15); add_point(8, 16);
		add_point(4, 8); add_point(511, 511); add_point(256, 0); add_point(0, 256);
		add_point(9, 2); add_point(3, 17);
		drain();

		// Single stack, zero counts, widest grid, off-center, wrapping indices
		write_reg(REG_STACKS, 32'd0);
		write_reg(REG_SECTORS, 32'd0);
		add_point(0, 0); add_point(1, 1); add_point(0, 1);
		drain();
		write_reg(REG_STACKS, 32'd511);
		write_reg(REG_SECTORS, 32'd300);
		write_reg(REG_RADIUS, 32'h7FFF_FFFF);
		write_reg(REG_CENTER_X, 32'h8000_0000);
		write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
		write_reg(REG_CENTER_Z, 32'hFFFF_0000);
		write_reg(REG_FIRST_INDEX, 32'hFFFF_FFF0);
		add_point(0, 0); add_point(255, 255); add_point(128, 64); add_point(256, 256);
		add_point(1, 0);
		drain();
		write_reg(REG_RADIUS, 32'd1);
		write_reg(REG_STACKS, 32'd2);
		write_reg(REG_SECTORS, 32'd1);
		add_point(0, 0); add_point(1, 0); add_point(2, 1);
		drain();

		// Random phases with fresh settings; mostly in-grid points
		for (int ph = 0; ph < 6; ph++) begin
			s = (ph == 0) ? 256 : $urandom_range(1, 40);
			t = (ph == 1) ? 256 : $urandom_range(1, 40);
			write_reg(REG_SECTORS, 32'(s));
			write_reg(REG_STACKS, 32'(t));
			write_reg(REG_RADIUS, (ph == 2) ? 32'h7FFF_FFFF : 32'($urandom_range(1, 32'h00FF_FFFF)));
			write_reg(REG_CENTER_X, $urandom());
			write_reg(REG_CENTER_Y, $urandom());
			write_reg(REG_CENTER_Z, $urandom());
			write_reg(REG_FIRST_INDEX, $urandom());
			for (int n = 0; n < 58; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 8)
					add_point($urandom_range(0, t), $urandom_range(0, s - 1));
				else
					add_point($urandom_range(0, 511), $urandom_range(0, 511));
			end
			drain();
		end

		$display("sent %0d grid points, checked %0d result items across several sphere settings",
			points_sent, results_seen);
		if (mismatches == 0 && mesh_q.size() == 0) begin
			$display("[uv_sphere_point_generator] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[uv_sphere_point_generator] ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
hdl/usps_pkg.sv
hdl/usps_recip.sv
hdl/usps_front.sv
hdl/usps_fifo.sv
hdl/usps_back.sv
hdl/uv_sphere_point_generator.sv
bench/uv_sphere_point_generator_tb.sv
